FILE: src/nfba_pkg.sv
// nfba_pkg: shared constants, types and helpers of the next-fit block allocator.
// No dependencies; used by every module in src.
package nfba_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
   localparam int ALIGN_LOG2   = 3;
   localparam int ALIGN_BYTES  = 1 << ALIGN_LOG2;
   localparam int HEADER_BYTES = 16;

   localparam int REQ_W   = 24;
   localparam int SIZE_W  = 25;
   localparam int ADDR_W  = 32;
   localparam int SUM_W   = 32;
   localparam int HND_W   = 7;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
   localparam logic [STAT_W-1:0] ST_OUT_OF_MEM  = 2'd1;
   localparam logic [STAT_W-1:0] ST_DOUBLE_FREE = 2'd2;
   localparam logic [STAT_W-1:0] ST_BAD_HANDLE  = 2'd3;

   localparam logic [SUM_W-1:0] HEAP_LIMIT_RST = 32'd1048576;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 144;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_SCAN    = 7'b0000010,
      S_APPEND  = 7'b0000100,
      S_HIT     = 7'b0001000,
      S_FREE_RD = 7'b0010000,
      S_FREE_CK = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] size;
      logic              used;
   } entry_type;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  addr;
      entry_type         data;
   } mem_wr_type;

   typedef struct packed {
      logic [HND_W-1:0]  handle;
      logic [REQ_W-1:0]  request_size;
      logic [CMD_W-1:0]  command;
   } req_type;

   // per-item outcome, without the running totals
   typedef struct packed {
      logic              was_reused;
      logic [SIZE_W-1:0] granted_size;
      logic [ADDR_W-1:0] payload_offset;
      logic [HND_W-1:0]  result_handle;
      logic [STAT_W-1:0] status;
   } res_type;

   typedef struct packed {
      logic [SUM_W-1:0]  heap_total;
      logic [SUM_W-1:0]  requested_total;
      logic [HND_W-1:0]  block_total;
      res_type           res;
   } rsp_type;

   // zero becomes one, then round up to the alignment
   function automatic logic [SIZE_W-1:0] round_up(input logic [REQ_W-1:0] n);
      logic [SIZE_W-1:0] v;
      v = (n == '0) ? SIZE_W'(1) : {1'b0, n};
      v = v + SIZE_W'(ALIGN_BYTES - 1);
      round_up = {v[SIZE_W-1:ALIGN_LOG2], {ALIGN_LOG2{1'b0}}};
   endfunction

endpackage

FILE: src/next_fit_block_allocator.sv
// Next-fit heap block allocator, top level: CSR, beat packing, output register.
// Instantiates nfba_seq and nfba_table. Uses nfba_pkg.
// The fit unit compares one entry per cycle. One item at a time: a new request is taken
// only once the last response has gone to the output register; a stalled response holds
// the next one. Sync reset empties the table, heap_limit = 1048576.
module next_fit_block_allocator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[1:0], request_size[25:2], handle[32:26], rest unused
   input  logic [39:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], result_handle[8:2], payload_offset[40:9], granted_size[65:41],
   // was_reused[66], block_total[73:67], requested_total[105:74],
   // heap_total[137:106], zero pad
   output logic [143:0] rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data
);

   localparam int RSP_BITS = $bits(nfba_pkg::rsp_type);
   localparam int REQ_BITS = $bits(nfba_pkg::req_type);

   logic [nfba_pkg::SUM_W-1:0] heap_limit_ff;
   logic                       rsp_valid_ff;
   nfba_pkg::rsp_type          rsp_data_ff;
   logic                       out_free;
   logic                       seq_valid;
   nfba_pkg::rsp_type          seq_rsp;
   nfba_pkg::req_type          req;
   nfba_pkg::mem_wr_type       mem_wr;
   logic [nfba_pkg::IDX_W-1:0] mem_rd_addr;
   nfba_pkg::entry_type        mem_rd_data;

   assign req = nfba_pkg::req_type'(req_tdata[REQ_BITS-1:0]);
   assign out_free = !rsp_valid_ff || rsp_tready;

   nfba_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_req      (req),
      .heap_limit  (heap_limit_ff),
      .mem_wr      (mem_wr),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .out_free    (out_free),
      .out_valid   (seq_valid),
      .out_rsp     (seq_rsp)
   );

   nfba_table u_table (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_limit_ff <= nfba_pkg::HEAP_LIMIT_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            heap_limit_ff <= csr_wr_data;
         end
         if (seq_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (seq_valid) begin
         rsp_data_ff <= seq_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(nfba_pkg::RSP_DATA_W - RSP_BITS){1'b0}}, rsp_data_ff};

endmodule

FILE: src/nfba_table.sv
// nfba_table: block table memory (start, size, used mark per entry).
// One write port, one read port with registered read data. Uses nfba_pkg.
module nfba_table (
   input  logic                        clock,
   input  nfba_pkg::mem_wr_type        wr,
   input  logic [nfba_pkg::IDX_W-1:0]  rd_addr,
   output nfba_pkg::entry_type         rd_data
);

   nfba_pkg::entry_type mem_ff [nfba_pkg::MAX_BLOCKS];
   nfba_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/nfba_seq.sv
// nfba_seq: command sequencer with the shared fit-compare unit and heap totals.
// Drives the table in nfba_table. Uses nfba_pkg.
module nfba_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  nfba_pkg::req_type           in_req,
   input  logic [nfba_pkg::SUM_W-1:0]  heap_limit,
   output nfba_pkg::mem_wr_type        mem_wr,
   output logic [nfba_pkg::IDX_W-1:0]  mem_rd_addr,
   input  nfba_pkg::entry_type         mem_rd_data,
   input  logic                        out_free,
   output logic                        out_valid,
   output nfba_pkg::rsp_type           out_rsp
);

   localparam int IW = nfba_pkg::IDX_W;
   localparam int CW = nfba_pkg::CNT_W;

   nfba_pkg::state_type state_ff, state_in;
   logic [nfba_pkg::REQ_W-1:0]  size_ff, size_in;
   logic [nfba_pkg::SIZE_W-1:0] need_ff, need_in;
   logic [nfba_pkg::HND_W-1:0]  hnd_ff, hnd_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [IW-1:0]               start_ff, start_in;
   logic [nfba_pkg::SUM_W-1:0]  req_sum_ff, req_sum_in;
   logic [nfba_pkg::SUM_W-1:0]  heap_sum_ff, heap_sum_in;
   logic [IW-1:0]               scan_idx_ff, scan_idx_in;
   logic [CW-1:0]               remain_ff, remain_in;
   logic                        chk_vld_ff, chk_vld_in;
   logic [IW-1:0]               chk_idx_ff, chk_idx_in;
   logic [IW-1:0]               hit_idx_ff, hit_idx_in;
   nfba_pkg::entry_type         hit_ent_ff, hit_ent_in;
   nfba_pkg::res_type           res_ff, res_in;

   logic          fit;
   logic          issue;
   logic [CW-1:0] scan_nxt;
   logic [IW-1:0] free_idx;
   logic [nfba_pkg::SUM_W:0] heap_need;

   // shared compare unit: one entry checked per cycle
   assign fit = chk_vld_ff && !mem_rd_data.used && (mem_rd_data.size >= need_ff);
   assign issue = (remain_ff != '0);
   assign scan_nxt = {1'b0, scan_idx_ff} + CW'(1);
   assign free_idx = IW'(hnd_ff - nfba_pkg::HND_W'(1));
   assign heap_need = {1'b0, heap_sum_ff} + (nfba_pkg::SUM_W + 1)'(nfba_pkg::HEADER_BYTES)
                      + (nfba_pkg::SUM_W + 1)'(need_ff);

   assign mem_rd_addr = (state_ff == nfba_pkg::S_SCAN) ? scan_idx_ff : free_idx;
   assign in_ready = (state_ff == nfba_pkg::S_IDLE);
   assign out_valid = (state_ff == nfba_pkg::S_DONE) && out_free;

   always_comb begin
      out_rsp.res             = res_ff;
      out_rsp.block_total     = nfba_pkg::HND_W'(count_ff);
      out_rsp.requested_total = req_sum_ff;
      out_rsp.heap_total      = heap_sum_ff;
   end

   always_comb begin
      state_in    = state_ff;
      size_in     = size_ff;
      need_in     = need_ff;
      hnd_in      = hnd_ff;
      count_in    = count_ff;
      start_in    = start_ff;
      req_sum_in  = req_sum_ff;
      heap_sum_in = heap_sum_ff;
      scan_idx_in = scan_idx_ff;
      remain_in   = remain_ff;
      chk_vld_in  = 1'b0;
      chk_idx_in  = chk_idx_ff;
      hit_idx_in  = hit_idx_ff;
      hit_ent_in  = hit_ent_ff;
      res_in      = res_ff;
      mem_wr      = '0;

      case (state_ff)
         nfba_pkg::S_IDLE: begin
            if (in_valid) begin
               size_in = in_req.request_size;
               need_in = nfba_pkg::round_up(in_req.request_size);
               hnd_in  = in_req.handle;
               res_in  = '0;
               state_in = nfba_pkg::S_DONE;
               case (in_req.command)
                  nfba_pkg::CMD_ALLOC: begin
                     remain_in   = count_ff;
                     scan_idx_in = ({1'b0, start_ff} < count_ff) ? start_ff : '0;
                     state_in    = (count_ff == '0) ? nfba_pkg::S_APPEND : nfba_pkg::S_SCAN;
                  end
                  nfba_pkg::CMD_FREE: begin
                     if (in_req.handle == '0) begin
                        res_in.status = nfba_pkg::ST_OK;
                     end else if (in_req.handle > nfba_pkg::HND_W'(count_ff)) begin
                        res_in.status = nfba_pkg::ST_BAD_HANDLE;
                     end else begin
                        state_in = nfba_pkg::S_FREE_RD;
                     end
                  end
                  nfba_pkg::CMD_RESET: begin
                     count_in    = '0;
                     start_in    = '0;
                     req_sum_in  = '0;
                     heap_sum_in = '0;
                  end
                  default: begin
                     res_in.status = nfba_pkg::ST_OK;
                  end
               endcase
            end
         end

         nfba_pkg::S_SCAN: begin
            // reads run one entry ahead of the compare
            if (issue) begin
               remain_in   = remain_ff - CW'(1);
               scan_idx_in = (scan_nxt == count_ff) ? '0 : scan_nxt[IW-1:0];
               chk_vld_in  = 1'b1;
               chk_idx_in  = scan_idx_ff;
            end
            if (fit) begin
               hit_idx_in = chk_idx_ff;
               hit_ent_in = mem_rd_data;
               chk_vld_in = 1'b0;
               remain_in  = '0;
               state_in   = nfba_pkg::S_HIT;
            end else if (!issue && !chk_vld_ff) begin
               state_in = nfba_pkg::S_APPEND;
            end
         end

         nfba_pkg::S_HIT: begin
            mem_wr.we        = 1'b1;
            mem_wr.addr      = hit_idx_ff;
            mem_wr.data      = hit_ent_ff;
            mem_wr.data.used = 1'b1;
            start_in         = hit_idx_ff;
            res_in.status         = nfba_pkg::ST_OK;
            res_in.result_handle  = nfba_pkg::HND_W'({1'b0, hit_idx_ff} + CW'(1));
            res_in.payload_offset = hit_ent_ff.start
                                    + nfba_pkg::ADDR_W'(nfba_pkg::HEADER_BYTES);
            res_in.granted_size   = hit_ent_ff.size;
            res_in.was_reused     = 1'b1;
            state_in = nfba_pkg::S_DONE;
         end

         nfba_pkg::S_APPEND: begin
            if (count_ff >= CW'(nfba_pkg::MAX_BLOCKS) || heap_need > {1'b0, heap_limit}) begin
               res_in.status = nfba_pkg::ST_OUT_OF_MEM;
            end else begin
               mem_wr.we         = 1'b1;
               mem_wr.addr       = count_ff[IW-1:0];
               mem_wr.data.start = heap_sum_ff;
               mem_wr.data.size  = need_ff;
               mem_wr.data.used  = 1'b1;
               count_in    = count_ff + CW'(1);
               heap_sum_in = heap_need[nfba_pkg::SUM_W-1:0];
               req_sum_in  = req_sum_ff + nfba_pkg::SUM_W'(size_ff);
               res_in.status         = nfba_pkg::ST_OK;
               res_in.result_handle  = nfba_pkg::HND_W'(count_ff + CW'(1));
               res_in.payload_offset = heap_sum_ff
                                       + nfba_pkg::ADDR_W'(nfba_pkg::HEADER_BYTES);
               res_in.granted_size   = need_ff;
               res_in.was_reused     = 1'b0;
            end
            state_in = nfba_pkg::S_DONE;
         end

         nfba_pkg::S_FREE_RD: begin
            state_in = nfba_pkg::S_FREE_CK;
         end

         nfba_pkg::S_FREE_CK: begin
            if (!mem_rd_data.used) begin
               res_in.status = nfba_pkg::ST_DOUBLE_FREE;
            end else begin
               mem_wr.we        = 1'b1;
               mem_wr.addr      = free_idx;
               mem_wr.data      = mem_rd_data;
               mem_wr.data.used = 1'b0;
               res_in.status    = nfba_pkg::ST_OK;
            end
            state_in = nfba_pkg::S_DONE;
         end

         nfba_pkg::S_DONE: begin
            if (out_free) begin
               state_in = nfba_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = nfba_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= nfba_pkg::S_IDLE;
         count_ff    <= '0;
         start_ff    <= '0;
         req_sum_ff  <= '0;
         heap_sum_ff <= '0;
         remain_ff   <= '0;
         chk_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         start_ff    <= start_in;
         req_sum_ff  <= req_sum_in;
         heap_sum_ff <= heap_sum_in;
         remain_ff   <= remain_in;
         chk_vld_ff  <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff     <= size_in;
      need_ff     <= need_in;
      hnd_ff      <= hnd_in;
      scan_idx_ff <= scan_idx_in;
      chk_idx_ff  <= chk_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_ent_ff  <= hit_ent_in;
      res_ff      <= res_in;
   end

endmodule
